[src/rzs_pkg.sv]
// ----------------------------------------------------------------------------
// rzs_pkg: shared constants and types of the rolling z-score pair signal
// Widths of the stream fields, of the running sums and of the test datapath.
// ----------------------------------------------------------------------------
package rzs_pkg;

  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned PTR_W      = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);

  localparam int unsigned TAG_W   = 32;
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned S_W     = PRICE_W + 1;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned CVAL_W  = 35;
  localparam int unsigned WL_W    = 7;
  localparam int unsigned LIM_W   = 10;
  localparam int unsigned THR_W   = 16;

  localparam int unsigned SUM_W  = S_W + CNT_W - 1;
  localparam int unsigned SQP_W  = 2 * (S_W - 1);
  localparam int unsigned SQ_W   = SQP_W + CNT_W;
  localparam int unsigned NSQ_W  = CNT_W + SQ_W;
  localparam int unsigned D_W    = SUM_W + 2;
  localparam int unsigned DM_W   = SUM_W + 1;
  localparam int unsigned AD_W   = SUM_W;
  localparam int unsigned V_W    = NSQ_W;
  localparam int unsigned VLO_W  = 31;
  localparam int unsigned VHI_W  = V_W - VLO_W;
  localparam int unsigned T2_W   = 2 * THR_W;
  localparam int unsigned CMP_W  = T2_W + V_W;
  localparam int unsigned L_W    = 2 * DM_W + 16;

  localparam int unsigned IN_FIELDS_W  = TAG_W + 2 * PRICE_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = TAG_W + ACT_W + POS_W + S_W + CVAL_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic [WL_W-1:0]  WL_RESET  = 7'd20;
  localparam logic [LIM_W-1:0] LIM_RESET = 10'd5;
  localparam logic [THR_W-1:0] THR_RESET = 16'd512;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_e;

  typedef struct packed {
    logic [CVAL_W-1:0] cval;
    logic [S_W-1:0]    spread;
    logic [POS_W-1:0]  pos;
    action_e           act;
    logic [TAG_W-1:0]  tag;
  } result_t;

endpackage

[src/rolling_zscore_pair_signal.sv]
// ----------------------------------------------------------------------------
// rolling_zscore_pair_signal: pairs-trading decision from a rolling z-score
// Keeps the last n price spreads in a ring RAM with running sums and emits
// buy/sell decisions and a closing record per series.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transaction per tick, two prices and a tag;
// tlast marks the final tick of a series. Output stream (m_axis): result
// records; tlast marks the closing record. Config channel: cfg_index_i
// selects window_length (0), position_limit (1) or z_threshold (2).
// Writing window_length restarts the window but keeps the position.
// cfg_ready_o is high only while no tick is in flight; a pending config
// write holds s_axis_tready low for that cycle.
// Timing: the ring RAM is read when a tick is taken and written in the cycle
// after; the z-score test then runs through a chain of registered multiplies.
// A tick in warm-up passes ST_SUM and ST_SQ; a tick with a decision goes on
// through ST_MUL1 to ST_MUL3 and ST_DECIDE, its record leaving in ST_EMIT_DEC.
// A final tick adds ST_CLOSE and ST_EMIT_CLS. One tick is in flight at a time.
// The output has a one-record register: a new tick is taken while a record
// waits there; when the receiver stalls with the register full, the next
// record holds in the block and s_axis_tready stays low.
// Reset clears the window, the position and the output and loads the
// default window 20, limit 5 and threshold 2.0; ring contents need no reset.
// ----------------------------------------------------------------------------
module rolling_zscore_pair_signal (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: date_tag, price_a, price_b
  input  logic [rzs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: tag_out, action, net_position, spread_out, closing_value, zero pad
  output logic [rzs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rzs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rzs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQ,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DECIDE,
    ST_EMIT_DEC,
    ST_CLOSE,
    ST_EMIT_CLS
  } state_e;

  state_e state_q;

  logic [rzs_pkg::WL_W-1:0]  wl_q;
  logic [rzs_pkg::LIM_W-1:0] lim_q;
  logic [rzs_pkg::THR_W-1:0] thr_q;

  logic [rzs_pkg::PTR_W-1:0]        ptr_q;
  logic [rzs_pkg::CNT_W-1:0]        fill_q;
  logic signed [rzs_pkg::SUM_W-1:0] sum_q;
  logic [rzs_pkg::SQ_W-1:0]         sumsq_q;
  logic signed [rzs_pkg::POS_W-1:0] pos_q;
  rzs_pkg::action_e                 act_q;

  logic                  out_valid_q;
  rzs_pkg::result_t      out_q;
  logic                  out_last_q;

  logic [rzs_pkg::TAG_W-1:0]        tag_q;
  logic signed [rzs_pkg::S_W-1:0]   s_q;
  logic                             last_q;
  logic                             full_q;
  logic [rzs_pkg::SQP_W-1:0]        sqn_q;
  logic [rzs_pkg::SQP_W-1:0]        sqo_q;
  logic signed [rzs_pkg::D_W-1:0]   d_q;
  logic [rzs_pkg::AD_W-1:0]         ad_q;
  logic [rzs_pkg::NSQ_W-1:0]        nsq_q;
  logic [rzs_pkg::NSQ_W-1:0]        ssq_q;
  logic [rzs_pkg::DM_W-1:0]         dm_q;
  logic [rzs_pkg::T2_W-1:0]         t2_q;
  logic                             dneg_q;
  logic [rzs_pkg::V_W-1:0]          v_q;
  logic                             vnz_q;
  logic [2*rzs_pkg::DM_W-1:0]       d2_q;
  logic [rzs_pkg::T2_W+rzs_pkg::VLO_W-1:0] plo_q;
  logic [rzs_pkg::T2_W+rzs_pkg::VHI_W-1:0] phi_q;
  logic signed [rzs_pkg::CVAL_W-1:0] cval_q;

  logic                              in_acc;
  logic                              cfg_acc;
  logic                              out_free;
  logic                              out_load;
  logic [rzs_pkg::CNT_W-1:0]         n_eff;
  logic                              ram_we;
  logic                              ram_re;
  logic [rzs_pkg::PTR_W-1:0]         ram_raddr;
  logic [rzs_pkg::S_W-1:0]           ram_rdata;
  logic signed [rzs_pkg::S_W-1:0]    s_in;
  logic signed [rzs_pkg::S_W-1:0]    os;
  logic signed [2*rzs_pkg::S_W-1:0]  sqn_full;
  logic signed [2*rzs_pkg::S_W-1:0]  sqo_full;
  logic signed [rzs_pkg::D_W-1:0]    ns;
  logic [rzs_pkg::CMP_W-1:0]         rhs;
  logic [rzs_pkg::CMP_W-1:0]         lhs;
  logic                              beyond;
  logic signed [rzs_pkg::POS_W:0]    pos_ext;
  logic signed [rzs_pkg::POS_W:0]    lim_ext;
  logic                              do_sell;
  logic                              do_buy;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = out_free && ((state_q == ST_EMIT_DEC) || (state_q == ST_EMIT_CLS));

  always_comb begin
    if (wl_q < rzs_pkg::WL_W'(2)) begin
      n_eff = rzs_pkg::CNT_W'(2);
    end else if (rzs_pkg::CNT_W'(wl_q) > rzs_pkg::CNT_W'(rzs_pkg::WINDOW_MAX)) begin
      n_eff = rzs_pkg::CNT_W'(rzs_pkg::WINDOW_MAX);
    end else begin
      n_eff = rzs_pkg::CNT_W'(wl_q);
    end
  end

  assign s_in = rzs_pkg::S_W'({1'b0, s_axis_tdata[rzs_pkg::TAG_W +: rzs_pkg::PRICE_W]})
              - rzs_pkg::S_W'({1'b0,
                  s_axis_tdata[rzs_pkg::TAG_W+rzs_pkg::PRICE_W +: rzs_pkg::PRICE_W]});

  assign ram_re    = in_acc;
  assign ram_raddr = ptr_q - n_eff[rzs_pkg::PTR_W-1:0];
  assign ram_we    = (state_q == ST_SUM);

  rzs_ram #(
    .WIDTH (rzs_pkg::S_W),
    .DEPTH (rzs_pkg::WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (s_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign os       = full_q ? $signed(ram_rdata) : '0;
  assign sqn_full = (2*rzs_pkg::S_W)'(s_q) * (2*rzs_pkg::S_W)'(s_q);
  assign sqo_full = (2*rzs_pkg::S_W)'(os) * (2*rzs_pkg::S_W)'(os);
  assign ns       = rzs_pkg::D_W'($signed({1'b0, n_eff})) * rzs_pkg::D_W'(s_q);

  assign rhs    = {phi_q, {rzs_pkg::VLO_W{1'b0}}} + rzs_pkg::CMP_W'(plo_q);
  assign lhs    = rzs_pkg::CMP_W'({d2_q, 16'b0});
  assign beyond = lhs > rhs;

  assign pos_ext = (rzs_pkg::POS_W+1)'(pos_q);
  assign lim_ext = $signed({2'b00, lim_q});
  assign do_sell = vnz_q && beyond && !dneg_q && (pos_ext > -lim_ext);
  assign do_buy  = vnz_q && beyond && dneg_q && (pos_ext < lim_ext);

  // Datapath stages: tick capture, the z-score test and the closing value.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          tag_q  <= s_axis_tdata[rzs_pkg::TAG_W-1:0];
          s_q    <= s_in;
          last_q <= s_axis_tlast;
          full_q <= (fill_q >= n_eff);
        end
      end
      ST_SUM: begin
        sqn_q <= sqn_full[rzs_pkg::SQP_W-1:0];
        sqo_q <= sqo_full[rzs_pkg::SQP_W-1:0];
      end
      ST_SQ: begin
        d_q  <= ns - rzs_pkg::D_W'(sum_q);
        ad_q <= sum_q[rzs_pkg::SUM_W-1] ? rzs_pkg::AD_W'(-sum_q) : rzs_pkg::AD_W'(sum_q);
      end
      ST_MUL1: begin
        nsq_q  <= rzs_pkg::NSQ_W'(n_eff) * rzs_pkg::NSQ_W'(sumsq_q);
        ssq_q  <= rzs_pkg::NSQ_W'(ad_q) * rzs_pkg::NSQ_W'(ad_q);
        dm_q   <= d_q[rzs_pkg::D_W-1] ? rzs_pkg::DM_W'(-d_q) : rzs_pkg::DM_W'(d_q);
        dneg_q <= d_q[rzs_pkg::D_W-1];
        t2_q   <= rzs_pkg::T2_W'(thr_q) * rzs_pkg::T2_W'(thr_q);
      end
      ST_MUL2: begin
        v_q   <= (nsq_q > ssq_q) ? (nsq_q - ssq_q) : '0;
        vnz_q <= (nsq_q > ssq_q);
        d2_q  <= (2*rzs_pkg::DM_W)'(dm_q) * (2*rzs_pkg::DM_W)'(dm_q);
      end
      ST_MUL3: begin
        plo_q <= (rzs_pkg::T2_W+rzs_pkg::VLO_W)'(t2_q)
               * (rzs_pkg::T2_W+rzs_pkg::VLO_W)'(v_q[rzs_pkg::VLO_W-1:0]);
        phi_q <= (rzs_pkg::T2_W+rzs_pkg::VHI_W)'(t2_q)
               * (rzs_pkg::T2_W+rzs_pkg::VHI_W)'(v_q[rzs_pkg::V_W-1:rzs_pkg::VLO_W]);
      end
      ST_CLOSE: begin
        cval_q <= rzs_pkg::CVAL_W'(s_q) * rzs_pkg::CVAL_W'(pos_q);
      end
      default: ;
    endcase
  end

  // Sequencer, settings, window state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wl_q        <= rzs_pkg::WL_RESET;
      lim_q       <= rzs_pkg::LIM_RESET;
      thr_q       <= rzs_pkg::THR_RESET;
      ptr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      pos_q       <= '0;
      act_q       <= rzs_pkg::ACT_NONE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_q   <= sum_q - rzs_pkg::SUM_W'(os) + rzs_pkg::SUM_W'(s_q);
          ptr_q   <= ptr_q + rzs_pkg::PTR_W'(1);
          if (!full_q) begin
            fill_q <= fill_q + rzs_pkg::CNT_W'(1);
          end
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          sumsq_q <= sumsq_q - rzs_pkg::SQ_W'(sqo_q) + rzs_pkg::SQ_W'(sqn_q);
          if (fill_q >= n_eff) begin
            state_q <= ST_MUL1;
          end else if (last_q) begin
            state_q <= ST_CLOSE;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_MUL3;
        ST_MUL3:  state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (do_sell) begin
            pos_q <= pos_q - rzs_pkg::POS_W'(1);
            act_q <= rzs_pkg::ACT_SELL;
          end else if (do_buy) begin
            pos_q <= pos_q + rzs_pkg::POS_W'(1);
            act_q <= rzs_pkg::ACT_BUY;
          end else begin
            act_q <= rzs_pkg::ACT_NONE;
          end
          state_q <= ST_EMIT_DEC;
        end
        ST_EMIT_DEC: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= 1'b0;
            out_q.tag    <= tag_q;
            out_q.act    <= act_q;
            out_q.pos    <= pos_q;
            out_q.spread <= s_q;
            out_q.cval   <= '0;
            state_q      <= last_q ? ST_CLOSE : ST_IDLE;
          end
        end
        ST_CLOSE: state_q <= ST_EMIT_CLS;
        ST_EMIT_CLS: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= 1'b1;
            out_q.tag    <= tag_q;
            out_q.act    <= rzs_pkg::ACT_NONE;
            out_q.pos    <= pos_q;
            out_q.spread <= s_q;
            out_q.cval   <= cval_q;
            ptr_q        <= '0;
            fill_q       <= '0;
            sum_q        <= '0;
            sumsq_q      <= '0;
            pos_q        <= '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_acc) begin
        unique case (cfg_index_i)
          rzs_pkg::REG_WINDOW: begin
            wl_q    <= cfg_data_i[rzs_pkg::WL_W-1:0];
            ptr_q   <= '0;
            fill_q  <= '0;
            sum_q   <= '0;
            sumsq_q <= '0;
          end
          rzs_pkg::REG_LIMIT:  lim_q <= cfg_data_i[rzs_pkg::LIM_W-1:0];
          rzs_pkg::REG_THRESH: thr_q <= cfg_data_i[rzs_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = rzs_pkg::OUT_TDATA_W'(out_q);

  a_take_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SUM)
    else $error("taken tick did not start the ring update");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rzs_pkg::CNT_W'(rzs_pkg::WINDOW_MAX))
    else $error("fill count beyond ring depth");

  a_fill_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |=> fill_q != '0)
    else $error("ring written but fill count is zero");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_CLS) && out_free |=> (fill_q == '0) && (pos_q == '0)
                                            && (sum_q == '0) && out_last_q)
    else $error("closing record did not clear the series state");

endmodule

[src/rzs_ram.sv]
// ----------------------------------------------------------------------------
// rzs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rzs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for rolling_zscore_pair_signal
// Streams price ticks into the block under random source gaps and sink
// stalls. A built-in predictor keeps its own rolling window, sums and
// position, works out the decision and closing records of every accepted
// tick, and compares them field by field with the output stream. Settings
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WAIT_MAX      = 12;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_TICKS  = 1530;
  localparam int unsigned PRINT_MAX     = 30;
  localparam longint      PRICE_MAX     = 64'hFFFFFF;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [rzs_pkg::TAG_W-1:0]   tag;
    logic [rzs_pkg::PRICE_W-1:0] price_a;
    logic [rzs_pkg::PRICE_W-1:0] price_b;
    logic                        last;
  } tick_t;

  typedef struct {
    logic [rzs_pkg::TAG_W-1:0]  tag;
    rzs_pkg::action_e           act;
    logic [rzs_pkg::POS_W-1:0]  pos;
    logic [rzs_pkg::S_W-1:0]    spread;
    logic [rzs_pkg::CVAL_W-1:0] cval;
    logic                       closing;
  } record_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic [rzs_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rzs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [rzs_pkg::CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [rzs_pkg::CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // predictor state and settings
  int          window_reg;
  int          limit_reg;
  int          thresh_reg;
  longint      spread_hist [rzs_pkg::WINDOW_MAX];
  int unsigned hist_ptr;
  int unsigned hist_fill;
  longint      run_sum;
  u64_t        run_sq_sum;
  int          net_pos;

  tick_t       tick_queue[$];
  record_t     record_queue[$];
  tick_t       cur_tick;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          src_quiet;
  bit          sink_quiet;

  int unsigned errors;
  int unsigned ticks_sent;
  int unsigned records_seen;
  int unsigned buys;
  int unsigned sells;
  int unsigned holds;
  int unsigned closings;
  int unsigned cfg_writes;
  int unsigned idle_cycles;

  rolling_zscore_pair_signal DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void restart_window();
    hist_ptr   = 0;
    hist_fill  = 0;
    run_sum    = 0;
    run_sq_sum = 0;
  endfunction

  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 40) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  // Rolling-window update and exact z-score test for one tick.
  function automatic void predict_tick(tick_t t);
    longint         s;
    longint         d;
    longint         oldest;
    u64_t           n;
    u64_t           nsq;
    u64_t           mag;
    u64_t           sum_sq;
    u64_t           var_term;
    u64_t           d_mag;
    logic [127:0]   lhs;
    logic [127:0]   rhs;
    logic [127:0]   wide_a;
    logic [127:0]   wide_b;
    bit             beyond;
    record_t        r;
    s = longint'(t.price_a) - longint'(t.price_b);
    n = (window_reg < 2) ? 2 :
        (window_reg > rzs_pkg::WINDOW_MAX) ? rzs_pkg::WINDOW_MAX : window_reg;
    if (hist_fill >= n) begin
      oldest = spread_hist[(hist_ptr + rzs_pkg::WINDOW_MAX - n) % rzs_pkg::WINDOW_MAX];
      run_sum -= oldest;
      run_sq_sum -= u64_t'(oldest * oldest);
    end else begin
      hist_fill++;
    end
    spread_hist[hist_ptr] = s;
    hist_ptr = (hist_ptr + 1) % rzs_pkg::WINDOW_MAX;
    run_sum += s;
    run_sq_sum += u64_t'(s * s);

    r.tag     = t.tag;
    r.spread  = rzs_pkg::S_W'(s);
    r.act     = rzs_pkg::ACT_NONE;
    r.cval    = '0;
    r.closing = 1'b0;
    if (hist_fill >= n) begin
      d        = longint'(n) * s - run_sum;
      nsq      = n * run_sq_sum;
      mag      = u64_t'((run_sum < 0) ? -run_sum : run_sum);
      sum_sq   = mag * mag;
      var_term = (nsq > sum_sq) ? nsq - sum_sq : 0;
      if (var_term != 0 && d != 0) begin
        d_mag  = u64_t'((d < 0) ? -d : d);
        wide_a = d_mag;
        lhs    = (wide_a * wide_a) << 16;
        wide_a = thresh_reg;
        wide_b = var_term;
        rhs    = wide_a * wide_a * wide_b;
        beyond = lhs > rhs;
        if (beyond && d > 0 && net_pos > -limit_reg) begin
          net_pos--;
          r.act = rzs_pkg::ACT_SELL;
        end else if (beyond && d < 0 && net_pos < limit_reg) begin
          net_pos++;
          r.act = rzs_pkg::ACT_BUY;
        end
      end
      r.pos = rzs_pkg::POS_W'(net_pos);
      record_queue.insert(record_queue.size(), r);
    end
    if (t.last) begin
      r.act     = rzs_pkg::ACT_NONE;
      r.pos     = rzs_pkg::POS_W'(net_pos);
      r.cval    = rzs_pkg::CVAL_W'(s * net_pos);
      r.closing = 1'b1;
      record_queue.insert(record_queue.size(), r);
      restart_window();
      net_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= PRINT_MAX)
      $display("%0t: record %0d %s mismatch: got %0h, want %0h",
               $time, records_seen, field, got, want);
  endtask

  task automatic check_record();
    rzs_pkg::result_t got;
    record_t          want;
    got = rzs_pkg::result_t'(m_axis_tdata[rzs_pkg::OUT_FIELDS_W-1:0]);
    records_seen++;
    if (record_queue.size() == 0) begin
      report_mismatch("unexpected record, tag", got.tag, '0);
    end else begin
      want = record_queue.pop_front();
      if (got.tag !== want.tag) report_mismatch("tag_out", got.tag, want.tag);
      if (got.act !== want.act) report_mismatch("action", got.act, want.act);
      if (got.pos !== want.pos) report_mismatch("net_position", got.pos, want.pos);
      if (got.spread !== want.spread) report_mismatch("spread_out", got.spread, want.spread);
      if (got.cval !== want.cval) report_mismatch("closing_value", got.cval, want.cval);
      if (m_axis_tlast !== want.closing)
        report_mismatch("is_closing", m_axis_tlast, want.closing);
      if (want.closing) closings++;
      else if (want.act == rzs_pkg::ACT_BUY) buys++;
      else if (want.act == rzs_pkg::ACT_SELL) sells++;
      else holds++;
    end
  endtask

  // tick source
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    tick_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(cur_tick);
        ticks_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          nxt = tick_queue.pop_front();
          cur_tick      <= nxt;
          s_axis_tdata  <= {nxt.price_b, nxt.price_a, nxt.tag};
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
          gap_left      <= draw_wait(src_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // record sink
  always @(posedge clk_i or negedge rst_ni) begin : record_monitor
    int unsigned wait_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_record();
      wait_n = draw_wait(sink_quiet);
      stall_left    <= wait_n;
      m_axis_tready <= (wait_n == 0);
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watchdog
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [rzs_pkg::CFG_IDX_W-1:0] idx,
                           logic [rzs_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      rzs_pkg::REG_WINDOW: begin
        window_reg = int'(value[rzs_pkg::WL_W-1:0]);
        restart_window();
      end
      rzs_pkg::REG_LIMIT:  limit_reg = int'(value[rzs_pkg::LIM_W-1:0]);
      rzs_pkg::REG_THRESH: thresh_reg = int'(value[rzs_pkg::THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (tick_queue.size() != 0 || s_axis_tvalid || record_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_tick(logic [rzs_pkg::TAG_W-1:0] tag, logic [rzs_pkg::PRICE_W-1:0] pa,
                           logic [rzs_pkg::PRICE_W-1:0] pb, bit last);
    tick_t t;
    t.tag     = tag;
    t.price_a = pa;
    t.price_b = pb;
    t.last    = last;
    tick_queue.insert(tick_queue.size(), t);
  endtask

  // Place a spread at a random price level.
  task automatic push_spread(logic [rzs_pkg::TAG_W-1:0] tag, longint s, bit last);
    longint pa;
    longint pb;
    if (s >= 0) begin
      pb = $urandom_range(0, PRICE_MAX - s);
      pa = pb + s;
    end else begin
      pa = $urandom_range(0, PRICE_MAX + s);
      pb = pa - s;
    end
    push_tick(tag, pa[rzs_pkg::PRICE_W-1:0], pb[rzs_pkg::PRICE_W-1:0], last);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n_items;
    int unsigned random_ticks;
    int unsigned series_left;
    int unsigned pick;
    int unsigned wl;
    int unsigned lim;
    int unsigned thr;
    longint      center;
    longint      scale;
    longint      jump;
    longint      s;
    bit          flat;

    window_reg  = int'(rzs_pkg::WL_RESET);
    limit_reg   = int'(rzs_pkg::LIM_RESET);
    thresh_reg  = int'(rzs_pkg::THR_RESET);
    net_pos     = 0;
    restart_window();
    series_left = 0;
    random_ticks = 0;
    center = 0;
    scale  = 1;
    flat   = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest window, zero threshold, tight limit: all actions, limit hold
    write_reg(rzs_pkg::REG_WINDOW, 16'd2);
    write_reg(rzs_pkg::REG_LIMIT, 16'd1);
    write_reg(rzs_pkg::REG_THRESH, 16'd0);
    @(negedge clk_i);
    push_tick(32'h0000_0000, 24'h000000, 24'h000000, 1'b0);
    push_tick(32'hFFFF_FFFF, 24'hFFFFFF, 24'h000000, 1'b0);
    push_tick(32'h0000_0002, 24'h000000, 24'hFFFFFF, 1'b0);
    push_tick(32'h0000_0003, 24'h000000, 24'hFFFFFF, 1'b0);
    push_tick(32'h0000_0004, 24'hFFFFFF, 24'h000000, 1'b0);
    push_tick(32'h0000_0005, 24'hFFFFFF, 24'h000000, 1'b0);
    push_spread(32'h0000_0006, 100, 1'b0);
    push_spread(32'h0000_0007, 200, 1'b0);
    push_spread(32'h0000_0008, 300, 1'b0);
    push_spread(32'hA5A5_5A5A, 400, 1'b1);
    push_tick(32'h5A5A_A5A5, 24'h000005, 24'h000009, 1'b1);
    wait_idle();

    // window below range, zero limit, top threshold
    write_reg(rzs_pkg::REG_WINDOW, 16'd0);
    write_reg(rzs_pkg::REG_LIMIT, 16'd0);
    write_reg(rzs_pkg::REG_THRESH, 16'hFFFF);
    @(negedge clk_i);
    push_tick(32'h1000_0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    push_tick(32'h1000_0001, 24'h000000, 24'h000001, 1'b0);
    push_tick(32'h1000_0002, 24'hFFFFFF, 24'h000000, 1'b0);
    push_tick(32'h1000_0003, 24'h123456, 24'h654321, 1'b1);
    wait_idle();

    // window of three at z = 1: flat start, then excursions
    write_reg(rzs_pkg::REG_WINDOW, 16'd3);
    write_reg(rzs_pkg::REG_LIMIT, 16'd1023);
    write_reg(rzs_pkg::REG_THRESH, 16'd256);
    @(negedge clk_i);
    push_spread(32'h2000_0000, 0, 1'b0);
    push_spread(32'h2000_0001, 0, 1'b0);
    push_spread(32'h2000_0002, 0, 1'b0);
    push_spread(32'h2000_0003, 0, 1'b0);
    push_spread(32'h2000_0004, 1000, 1'b0);
    push_spread(32'h2000_0005, -1000, 1'b0);
    push_spread(32'h2000_0006, -1000, 1'b0);
    push_spread(32'h2000_0007, -5000, 1'b1);
    wait_idle();

    phase = 0;
    while (random_ticks < RANDOM_TICKS) begin
      case (phase)
        0: begin
          wl = 127; lim = 1023; thr = 0;
        end
        1: begin
          wl = 64; lim = 2; thr = 512;
        end
        2: begin
          wl = 1; lim = 3; thr = 128;
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) wl = $urandom_range(0, 1);
          else if (pick == 1) wl = $urandom_range(65, 127);
          else if (pick == 2) wl = 2;
          else if (pick == 3) wl = 64;
          else wl = $urandom_range(2, 24);
          pick = $urandom_range(0, 5);
          if (pick == 0) lim = 0;
          else if (pick == 1) lim = 1023;
          else if (pick == 2) lim = $urandom_range(0, 1023);
          else lim = $urandom_range(1, 6);
          pick = $urandom_range(0, 6);
          if (pick == 0) thr = 0;
          else if (pick == 1) thr = 16'hFFFF;
          else if (pick == 2) thr = $urandom_range(0, 16'hFFFF);
          else if (pick == 3) thr = 256;
          else thr = $urandom_range(64, 768);
        end
      endcase
      if (phase < 3 || $urandom_range(0, 2) != 0)
        write_reg(rzs_pkg::REG_WINDOW, rzs_pkg::CFG_DATA_W'(wl));
      if (phase < 3 || $urandom_range(0, 1) != 0)
        write_reg(rzs_pkg::REG_LIMIT, rzs_pkg::CFG_DATA_W'(lim));
      if (phase < 3 || $urandom_range(0, 1) != 0)
        write_reg(rzs_pkg::REG_THRESH, rzs_pkg::CFG_DATA_W'(thr));
      @(negedge clk_i);

      n_items = $urandom_range(60, 200);
      if (n_items > RANDOM_TICKS - random_ticks) n_items = RANDOM_TICKS - random_ticks;
      repeat (n_items) begin
        if (series_left == 0) begin
          series_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) :
                                                     $urandom_range(10, 3 * rzs_pkg::WINDOW_MAX);
          pick = $urandom_range(0, 3);
          scale = (pick == 0) ? 3 : (pick == 1) ? 100 : (pick == 2) ? 10000 : 1000000;
          center = longint'($urandom_range(0, 24'hFFFFFF)) - 24'h7FFFFF;
          flat = ($urandom_range(0, 15) == 0);
        end
        series_left--;
        if ($urandom_range(0, 19) == 0) begin
          push_tick($urandom(), rzs_pkg::PRICE_W'($urandom_range(0, 24'hFFFFFF)),
                    rzs_pkg::PRICE_W'($urandom_range(0, 24'hFFFFFF)), series_left == 0);
        end else begin
          s = center;
          if (!flat) begin
            s += longint'($urandom_range(0, 2 * scale)) - scale;
            if ($urandom_range(0, 9) == 0) begin
              jump = scale * longint'($urandom_range(3, 8));
              if ($urandom_range(0, 1) != 0) s += jump;
              else s -= jump;
            end
          end
          if (s > PRICE_MAX) s = PRICE_MAX;
          if (s < -PRICE_MAX) s = -PRICE_MAX;
          push_spread($urandom(), s, series_left == 0);
        end
      end
      random_ticks += n_items;
      wait_idle();
      phase++;
    end

    wait_idle();
    $display("Run covered %0d ticks in %0d random phases after the directed set, %0d writes",
             ticks_sent, phase, cfg_writes);
    $display("Records checked: %0d (%0d buy, %0d sell, %0d hold, %0d closing)",
             records_seen, buys, sells, holds, closings);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
